// File: hdl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg: shared constants for collision time prediction
// Field widths of the request and response channels, and the default
// number of fraction bits of the fixed point format.
// ----------------------------------------------------------------------------
package ctp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 20;
   localparam int RAD_W     = 16;
   localparam int TIME_W    = 32;

endpackage

// File: hdl/ctp_if.sv
// ----------------------------------------------------------------------------
// ctp_if: request and response channels of collision time prediction
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface ctp_req_if;
   logic                               valid;
   logic                               ready;
   logic                               same_particle;
   logic signed [ctp_pkg::POS_W-1:0]   a_pos_x;
   logic signed [ctp_pkg::POS_W-1:0]   a_pos_y;
   logic signed [ctp_pkg::POS_W-1:0]   a_vel_x;
   logic signed [ctp_pkg::POS_W-1:0]   a_vel_y;
   logic        [ctp_pkg::RAD_W-1:0]   a_rad;
   logic signed [ctp_pkg::POS_W-1:0]   b_pos_x;
   logic signed [ctp_pkg::POS_W-1:0]   b_pos_y;
   logic signed [ctp_pkg::POS_W-1:0]   b_vel_x;
   logic signed [ctp_pkg::POS_W-1:0]   b_vel_y;
   logic        [ctp_pkg::RAD_W-1:0]   b_rad;

   modport source (output valid, same_particle, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_rad,
                   b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_rad, input ready);
   modport sink   (input valid, same_particle, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_rad,
                   b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_rad, output ready);
endinterface

interface ctp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ctp_pkg::TIME_W-1:0]        pair_time;
   logic                              pair_hit;
   logic [ctp_pkg::TIME_W-1:0]        vwall_time;
   logic                              vwall_hit;
   logic [ctp_pkg::TIME_W-1:0]        hwall_time;
   logic                              hwall_hit;

   modport source (output valid, pair_time, pair_hit, vwall_time, vwall_hit, hwall_time,
                   hwall_hit, input ready);
   modport sink   (input valid, pair_time, pair_hit, vwall_time, vwall_hit, hwall_time,
                   hwall_hit, output ready);
endinterface

// File: hdl/collision_time_prediction.sv
// ----------------------------------------------------------------------------
// collision_time_prediction: pipelined disc collision time predictor
// Predicts the contact time of two discs and the wall times of the first
// disc, one request per cycle while the skid register is empty, through a deep pipeline.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// req_ch   | in        | same_particle, disc A and disc B position/velocity/radius
// rsp_ch   | out       | pair, vertical wall and horizontal wall time and hit flag
//
// One request is accepted per cycle while the skid register is empty; each
// result passes through 6 arithmetic stages, 43 square root stages, 2 setup
// stages and 32 division stages, one root or quotient bit per stage.
// Reset clears the valid bits and the skid valid bit only.
// A stalled result is parked in a skid register; the pipeline holds while it
// is full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module collision_time_prediction #(
   parameter int FRAC_BITS = ctp_pkg::FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   ctp_req_if.sink     req_ch,
   ctp_rsp_if.source   rsp_ch
);

   localparam int TW    = ctp_pkg::TIME_W;
   localparam int PW    = ctp_pkg::POS_W;
   localparam int S_W   = 43;
   localparam int SQ_W  = 88;
   localparam int NUM_W = 43;
   localparam int DEN_W = 42;
   localparam int DW    = NUM_W + TW + FRAC_BITS;
   localparam int WW    = PW + FRAC_BITS + 2;
   localparam int SQ0   = 6;
   localparam int PNUM  = SQ0 + S_W;
   localparam int OVF   = PNUM + 1;
   localparam int DIV0  = OVF + 1;
   localparam int NST   = DIV0 + TW;

   typedef struct packed {
      logic                    same;
      logic signed [20:0]      dx;
      logic signed [20:0]      dy;
      logic signed [20:0]      dvx;
      logic signed [20:0]      dvy;
      logic        [16:0]      sig;
      logic signed [41:0]      p_xv;
      logic signed [41:0]      p_yv;
      logic        [41:0]      p_vxx;
      logic        [41:0]      p_vyy;
      logic        [41:0]      p_xx;
      logic        [41:0]      p_yy;
      logic        [33:0]      p_ss;
      logic        [41:0]      m;
      logic        [41:0]      dvdv;
      logic        [41:0]      me;
      logic                    ok;
      logic                    e_le0;
      logic [6:0][41:0]        pp;
      logic        [SQ_W-1:0]  a;
      logic        [SQ_W-1:0]  b;
      logic        [SQ_W-1:0]  rem_s;
      logic        [S_W-1:0]   root;
      logic [2:0]              hit;
      logic [2:0]              zero;
      logic [2:0]              sat;
      logic [2:0][NUM_W-1:0]   dnum;
      logic [2:0][DEN_W-1:0]   dden;
      logic [2:0][DW-1:0]      drem;
      logic [2:0][TW-1:0]      dq;
   } stage_type;

   typedef struct packed {
      logic                    hit;
      logic                    zero;
      logic [NUM_W-1:0]        num;
      logic [DEN_W-1:0]        den;
   } wall_type;

   typedef struct packed {
      logic [TW-1:0]           pair_time;
      logic                    pair_hit;
      logic [TW-1:0]           vwall_time;
      logic                    vwall_hit;
      logic [TW-1:0]           hwall_time;
      logic                    hwall_hit;
   } out_type;

   function automatic wall_type wall_prep(logic signed [PW-1:0] p, logic signed [PW-1:0] v);
      logic signed [WW-1:0] one;
      logic signed [WW-1:0] num;
      wall_type             w;
      one    = WW'(1) <<< FRAC_BITS;
      num    = (v > 0) ? (one - WW'(p)) : (-one - WW'(p));
      w.hit  = (v != 0);
      w.zero = (v > 0 && num <= 0) || (v < 0 && num >= 0);
      w.num  = (num < 0) ? NUM_W'(-num) : NUM_W'(num);
      w.den  = (v < 0) ? DEN_W'(-(PW + 1)'(v)) : DEN_W'(v);
      return w;
   endfunction

   stage_type        st_ff [NST];
   stage_type        st_in [NST];
   logic [NST-1:0]   vld_ff;
   logic             en;
   out_type          out_last;
   out_type          skid_ff;
   logic             skid_vld_ff;

   assign en           = !skid_vld_ff;
   assign req_ch.ready = en;

   for (genvar g = 0; g < NST; g++) begin : g_stage
      if (g == 0) begin : g_prep
         always_comb begin
            wall_type wx;
            wall_type wy;
            st_in[g]      = 'x;
            wx            = wall_prep(req_ch.a_pos_x, req_ch.a_vel_x);
            wy            = wall_prep(req_ch.a_pos_y, req_ch.a_vel_y);
            st_in[g].same = req_ch.same_particle;
            st_in[g].dx   = 21'(req_ch.b_pos_x) - 21'(req_ch.a_pos_x);
            st_in[g].dy   = 21'(req_ch.b_pos_y) - 21'(req_ch.a_pos_y);
            st_in[g].dvx  = 21'(req_ch.b_vel_x) - 21'(req_ch.a_vel_x);
            st_in[g].dvy  = 21'(req_ch.b_vel_y) - 21'(req_ch.a_vel_y);
            st_in[g].sig  = 17'(req_ch.a_rad) + 17'(req_ch.b_rad);
            st_in[g].hit[1]  = wx.hit;
            st_in[g].zero[1] = wx.zero;
            st_in[g].dnum[1] = wx.num;
            st_in[g].dden[1] = wx.den;
            st_in[g].hit[2]  = wy.hit;
            st_in[g].zero[2] = wy.zero;
            st_in[g].dnum[2] = wy.num;
            st_in[g].dden[2] = wy.den;
         end
      end else if (g == 1) begin : g_prod
         always_comb begin
            st_in[g]       = st_ff[g-1];
            st_in[g].p_xv  = 42'(st_ff[g-1].dx) * 42'(st_ff[g-1].dvx);
            st_in[g].p_yv  = 42'(st_ff[g-1].dy) * 42'(st_ff[g-1].dvy);
            st_in[g].p_vxx = 42'(42'(st_ff[g-1].dvx) * 42'(st_ff[g-1].dvx));
            st_in[g].p_vyy = 42'(42'(st_ff[g-1].dvy) * 42'(st_ff[g-1].dvy));
            st_in[g].p_xx  = 42'(42'(st_ff[g-1].dx) * 42'(st_ff[g-1].dx));
            st_in[g].p_yy  = 42'(42'(st_ff[g-1].dy) * 42'(st_ff[g-1].dy));
            st_in[g].p_ss  = 34'(st_ff[g-1].sig) * 34'(st_ff[g-1].sig);
         end
      end else if (g == 2) begin : g_sum
         always_comb begin
            logic signed [42:0] dvdr;
            logic signed [42:0] e;
            logic        [41:0] drdr;
            st_in[g]       = st_ff[g-1];
            dvdr           = 43'(st_ff[g-1].p_xv) + 43'(st_ff[g-1].p_yv);
            drdr           = st_ff[g-1].p_xx + st_ff[g-1].p_yy;
            e              = $signed({1'b0, drdr}) - $signed({9'b0, st_ff[g-1].p_ss});
            st_in[g].dvdv  = st_ff[g-1].p_vxx + st_ff[g-1].p_vyy;
            st_in[g].m     = (dvdr < 0) ? 42'(-dvdr) : 42'(dvdr);
            st_in[g].me    = (e < 0) ? 42'(-e) : 42'(e);
            st_in[g].e_le0 = (e <= 0);
            st_in[g].ok    = !st_ff[g-1].same && (dvdr <= 0) &&
                             (st_ff[g-1].p_vxx + st_ff[g-1].p_vyy != 42'd0);
         end
      end else if (g == 3) begin : g_part
         always_comb begin
            logic [20:0] mh, ml, dh, dl, eh, el;
            st_in[g]       = st_ff[g-1];
            mh             = st_ff[g-1].m[41:21];
            ml             = st_ff[g-1].m[20:0];
            dh             = st_ff[g-1].dvdv[41:21];
            dl             = st_ff[g-1].dvdv[20:0];
            eh             = st_ff[g-1].me[41:21];
            el             = st_ff[g-1].me[20:0];
            st_in[g].pp[0] = 42'(mh) * 42'(mh);
            st_in[g].pp[1] = 42'(mh) * 42'(ml);
            st_in[g].pp[2] = 42'(ml) * 42'(ml);
            st_in[g].pp[3] = 42'(dh) * 42'(eh);
            st_in[g].pp[4] = 42'(dh) * 42'(el);
            st_in[g].pp[5] = 42'(dl) * 42'(eh);
            st_in[g].pp[6] = 42'(dl) * 42'(el);
         end
      end else if (g == 4) begin : g_comb
         always_comb begin
            st_in[g]   = st_ff[g-1];
            st_in[g].a = (SQ_W'(st_ff[g-1].pp[0]) << 42) + (SQ_W'(st_ff[g-1].pp[1]) << 22) +
                         SQ_W'(st_ff[g-1].pp[2]);
            st_in[g].b = (SQ_W'(st_ff[g-1].pp[3]) << 42) +
                         ((SQ_W'(st_ff[g-1].pp[4]) + SQ_W'(st_ff[g-1].pp[5])) << 21) +
                         SQ_W'(st_ff[g-1].pp[6]);
         end
      end else if (g == 5) begin : g_disc
         always_comb begin
            st_in[g]       = st_ff[g-1];
            st_in[g].ok    = st_ff[g-1].ok && (st_ff[g-1].e_le0 || st_ff[g-1].a >= st_ff[g-1].b);
            st_in[g].rem_s = st_ff[g-1].e_le0 ? (st_ff[g-1].a + st_ff[g-1].b)
                                              : (st_ff[g-1].a - st_ff[g-1].b);
            st_in[g].root  = '0;
         end
      end else if (g < PNUM) begin : g_sqrt
         localparam int K = S_W - 1 - (g - SQ0);
         always_comb begin
            logic [SQ_W-1:0] trial;
            st_in[g] = st_ff[g-1];
            // Restoring square root: the remainder stays d minus root squared.
            trial    = (SQ_W'(st_ff[g-1].root) << (K + 1)) + (SQ_W'(1) << (2 * K));
            if (st_ff[g-1].rem_s >= trial) begin
               st_in[g].rem_s   = st_ff[g-1].rem_s - trial;
               st_in[g].root[K] = 1'b1;
            end
         end
      end else if (g == PNUM) begin : g_pnum
         always_comb begin
            st_in[g]         = st_ff[g-1];
            st_in[g].hit[0]  = st_ff[g-1].ok;
            st_in[g].zero[0] = (st_ff[g-1].root >= S_W'(st_ff[g-1].m));
            st_in[g].dnum[0] = NUM_W'(S_W'(st_ff[g-1].m) - st_ff[g-1].root);
            st_in[g].dden[0] = st_ff[g-1].dvdv;
         end
      end else if (g == OVF) begin : g_ovf
         always_comb begin
            st_in[g] = st_ff[g-1];
            for (int i = 0; i < 3; i++) begin
               // The quotient fits the time field only below den times 2^(32-F).
               st_in[g].sat[i]  = DW'(st_ff[g-1].dnum[i]) >=
                                  (DW'(st_ff[g-1].dden[i]) << (TW - FRAC_BITS));
               st_in[g].drem[i] = DW'(st_ff[g-1].dnum[i]) << FRAC_BITS;
               st_in[g].dq[i]   = '0;
            end
         end
      end else begin : g_div
         localparam int K = TW - 1 - (g - DIV0);
         always_comb begin
            logic [DW-1:0] sub;
            st_in[g] = st_ff[g-1];
            for (int i = 0; i < 3; i++) begin
               sub = DW'(st_ff[g-1].dden[i]) << K;
               if (st_ff[g-1].drem[i] >= sub) begin
                  st_in[g].drem[i]  = st_ff[g-1].drem[i] - sub;
                  st_in[g].dq[i][K] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_ch.valid};
      end
   end

   always_comb begin
      out_type o;
      logic [2:0][TW-1:0] t;
      for (int i = 0; i < 3; i++) begin
         if (!st_ff[NST-1].hit[i] || (!st_ff[NST-1].zero[i] && st_ff[NST-1].sat[i])) begin
            t[i] = '1;
         end else if (st_ff[NST-1].zero[i]) begin
            t[i] = '0;
         end else begin
            t[i] = st_ff[NST-1].dq[i];
         end
      end
      o.pair_time  = t[0];
      o.pair_hit   = st_ff[NST-1].hit[0];
      o.vwall_time = t[1];
      o.vwall_hit  = st_ff[NST-1].hit[1];
      o.hwall_time = t[2];
      o.hwall_hit  = st_ff[NST-1].hit[2];
      out_last     = o;
   end

   // The skid register takes the last stage when its result is not taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         skid_vld_ff <= !rsp_ch.ready;
      end else begin
         skid_vld_ff <= vld_ff[NST-1] && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_ff <= out_last;
      end
   end

   always_comb begin
      out_type o;
      o                 = skid_vld_ff ? skid_ff : out_last;
      rsp_ch.valid      = skid_vld_ff || vld_ff[NST-1];
      rsp_ch.pair_time  = o.pair_time;
      rsp_ch.pair_hit   = o.pair_hit;
      rsp_ch.vwall_time = o.vwall_time;
      rsp_ch.vwall_hit  = o.vwall_hit;
      rsp_ch.hwall_time = o.hwall_time;
      rsp_ch.hwall_hit  = o.hwall_hit;
   end

endmodule
